/* rtl/bpfa_pkg.sv */
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page frame allocator: sizes,
// request codes, register index and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

  // store geometry
  localparam int MAX_FRAMES  = 16384;
  localparam int STORE_BYTES = MAX_FRAMES / 8;
  localparam int ROW_W       = 64;
  localparam int ROWS        = MAX_FRAMES / ROW_W;
  localparam int ROW_AW      = $clog2(ROWS);
  localparam int BIT_AW      = $clog2(ROW_W);

  // field widths
  localparam int FRAME_W = 14;
  localparam int COUNT_W = 15;
  localparam int BYTES_W = 12;

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam logic REG_BITMAP_BYTES = 1'b0;

  // request codes
  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RESERVE = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  // commands from the controller
  typedef struct packed {
    logic accept;
    logic load_row;
    logic alloc_next_row;
    logic bit_next;
    logic alloc_take;
    logic range_step;
    logic write_back;
    logic set_fail;
    logic out_load;
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_reserve;
    logic count_bad;
    logic start_oor;
    logic count_zero;
    logic row_any_free;
    logic alloc_last_row;
    logic alloc_bit_ok;
    logic bit_taken;
    logic walk_last;
    logic row_end;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/bpfa_datapath.sv */
// ----------------------------------------------------------------------------
// bpfa_datapath
// Row-wide bitmap store with per-row valid bits, working row register,
// frame pointer, remaining count, free counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bpfa_pkg::cmd_t                  cmd,
  output bpfa_pkg::stat_t                      stat,
  input  wire logic [1:0]                      in_req_type,
  input  wire logic [bpfa_pkg::FRAME_W-1:0]    in_frame,
  input  wire logic [bpfa_pkg::COUNT_W-1:0]    in_count,
  input  wire logic [bpfa_pkg::BYTES_W-1:0]    bitmap_bytes,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic                                 out_status,
  output logic [bpfa_pkg::FRAME_W-1:0]         out_given_frame,
  output logic [bpfa_pkg::COUNT_W-1:0]         out_free_frames
);

  localparam int RW  = bpfa_pkg::ROW_W;
  localparam int RA  = bpfa_pkg::ROW_AW;
  localparam int BA  = bpfa_pkg::BIT_AW;
  localparam int FW  = bpfa_pkg::FRAME_W;
  localparam int CW  = bpfa_pkg::COUNT_W;
  localparam int BW  = bpfa_pkg::BYTES_W;

  // bitmap store, one row of frames per entry
  logic [RW-1:0]        mem [bpfa_pkg::ROWS];
  logic [bpfa_pkg::ROWS-1:0] row_valid_r;
  logic [RW-1:0]        rd_data_r;
  logic                 rd_valid_r;

  bpfa_pkg::req_t       kind_r;
  logic [FW-1:0]        f_r;
  logic [CW-1:0]        n_r;
  logic [CW-1:0]        limit_r;
  logic [RW-1:0]        work_r, work_nxt;
  logic [RA-1:0]        wb_row_r;
  logic [CW-1:0]        free_total_r, free_nxt;
  logic                 status_r;
  logic [FW-1:0]        given_r;

  logic                 out_valid_r;
  logic                 out_status_r;
  logic [FW-1:0]        out_given_r;
  logic [CW-1:0]        out_free_r;

  logic [BW-1:0]        used_bytes;
  logic [CW-1:0]        limit;
  logic [RA-1:0]        row;
  logic [BA-1:0]        bitpos;
  logic [RA:0]          row_ext, next_row, lim_row;
  logic [BA-1:0]        lim_off;
  logic [RW-1:0]        eff_row, lim_mask, zero_mask;
  logic [CW-1:0]        f_ext, f_inc;

  // tracked frame limit, register clamped to the store size
  always_comb begin
    used_bytes = (bitmap_bytes > BW'(bpfa_pkg::STORE_BYTES)) ?
                 BW'(bpfa_pkg::STORE_BYTES) : bitmap_bytes;
    limit      = {used_bytes, 3'b000};
  end

  assign row      = f_r[FW-1:BA];
  assign bitpos   = f_r[BA-1:0];
  assign row_ext  = {1'b0, row};
  assign next_row = row_ext + (RA+1)'(1);
  assign lim_row  = limit_r[CW-1:BA];
  assign lim_off  = limit_r[BA-1:0];
  assign f_ext    = {1'b0, f_r};
  assign f_inc    = f_ext + CW'(1);

  // a row never written reads as all taken
  assign eff_row = rd_valid_r ? rd_data_r : '1;

  // frames of the current row that an allocate may hand out
  always_comb begin
    if (row_ext < lim_row) begin
      lim_mask = '1;
    end else if (row_ext == lim_row) begin
      lim_mask = (RW'(1) << lim_off) - RW'(1);
    end else begin
      lim_mask = '0;
    end
    zero_mask = (row == '0) ? ~RW'(1) : '1;
  end

  // status towards the controller
  always_comb begin
    stat.is_alloc       = (kind_r == bpfa_pkg::REQ_ALLOC);
    stat.is_free        = (kind_r == bpfa_pkg::REQ_FREE);
    stat.is_reserve     = (kind_r == bpfa_pkg::REQ_RESERVE);
    stat.count_bad      = (n_r != CW'(1));
    stat.start_oor      = (f_ext >= limit_r);
    stat.count_zero     = (n_r == '0);
    stat.row_any_free   = |(~eff_row & lim_mask & zero_mask);
    stat.alloc_last_row = ({next_row, BA'(0)} >= limit_r);
    stat.alloc_bit_ok   = !work_r[bitpos] && (f_r != '0) && (f_ext < limit_r);
    stat.bit_taken      = work_r[bitpos];
    stat.walk_last      = (n_r == CW'(1)) || (f_inc >= limit_r);
    stat.row_end        = &bitpos;
    stat.out_free       = !out_valid_r || !out_stall;
  end

  // working row and free counter updates
  always_comb begin
    work_nxt = work_r;
    free_nxt = free_total_r;
    if (cmd.load_row) begin
      work_nxt = eff_row;
    end else if (cmd.alloc_take) begin
      work_nxt[bitpos] = 1'b1;
      if (free_total_r != '0) free_nxt = free_total_r - CW'(1);
    end else if (cmd.range_step) begin
      if (kind_r == bpfa_pkg::REQ_RESERVE) begin
        if (!work_r[bitpos]) begin
          work_nxt[bitpos] = 1'b1;
          if (free_total_r != '0) free_nxt = free_total_r - CW'(1);
        end
      end else if (work_r[bitpos]) begin
        work_nxt[bitpos] = 1'b0;
        if (free_total_r < CW'(bpfa_pkg::MAX_FRAMES)) free_nxt = free_total_r + CW'(1);
      end
    end
  end

  // store: registered read at the current row, write-back of the working row
  always_ff @(posedge clk) begin
    rd_data_r  <= mem[row];
    rd_valid_r <= row_valid_r[row];
    if (cmd.write_back) begin
      mem[wb_row_r] <= work_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r  <= '0;
      free_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.write_back) row_valid_r[wb_row_r] <= 1'b1;
      free_total_r <= free_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (cmd.load_row) wb_row_r <= row;
    if (cmd.accept) begin
      kind_r   <= bpfa_pkg::req_t'(in_req_type);
      f_r      <= (bpfa_pkg::req_t'(in_req_type) == bpfa_pkg::REQ_ALLOC) ? '0 : in_frame;
      n_r      <= in_count;
      limit_r  <= limit;
      status_r <= 1'b0;
      given_r  <= '0;
    end else begin
      if (cmd.alloc_next_row) f_r <= {next_row[RA-1:0], BA'(0)};
      if (cmd.bit_next)       f_r <= f_r + FW'(1);
      if (cmd.range_step) begin
        f_r <= f_inc[FW-1:0];
        n_r <= n_r - CW'(1);
      end
      if (cmd.alloc_take) given_r  <= f_r;
      if (cmd.set_fail)   status_r <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_given_r  <= given_r;
      out_free_r   <= free_total_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_given_frame = out_given_r;
  assign out_free_frames = out_free_r;

endmodule

`default_nettype wire

/* rtl/bpfa_ctrl.sv */
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Request sequencer: decodes a transaction, steps the row scan or the frame
// walk, schedules write-backs and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire bpfa_pkg::stat_t stat,
  output bpfa_pkg::cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_RD      = 9'b000000100,
    S_LOAD    = 9'b000001000,
    S_ABIT    = 9'b000010000,
    S_WALK    = 9'b000100000,
    S_WB_NEXT = 9'b001000000,
    S_WB_LAST = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_alloc) begin
          if (stat.count_bad) begin
            cmd.set_fail = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_LOAD;
          end
        end else if (stat.start_oor) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_DONE;
        end else if (stat.is_free) begin
          if (stat.count_bad) begin
            cmd.set_fail = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_LOAD;
          end
        end else if (stat.count_zero) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_RD: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_row = 1'b1;
        if (stat.is_alloc) begin
          if (stat.row_any_free) begin
            state_nxt = S_ABIT;
          end else if (stat.alloc_last_row) begin
            cmd.set_fail = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            cmd.alloc_next_row = 1'b1;
            state_nxt          = S_RD;
          end
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_ABIT: begin
        if (stat.alloc_bit_ok) begin
          cmd.alloc_take = 1'b1;
          state_nxt      = S_WB_LAST;
        end else begin
          cmd.bit_next = 1'b1;
        end
      end
      S_WALK: begin
        if (stat.is_reserve && stat.bit_taken) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_WB_LAST;
        end else begin
          cmd.range_step = 1'b1;
          if (stat.walk_last) begin
            state_nxt = S_WB_LAST;
          end else if (stat.row_end) begin
            state_nxt = S_WB_NEXT;
          end
        end
      end
      S_WB_NEXT: begin
        // the next row is read while the old one is written back
        cmd.write_back = 1'b1;
        state_nxt      = S_LOAD;
      end
      S_WB_LAST: begin
        cmd.write_back = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/bitmap_page_frame_allocator_top.sv */
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_top
// Page frame allocator over a bitmap of 64-frame rows, with a register port
// that sets how many bitmap bytes are tracked.
// ----------------------------------------------------------------------------
// flow: one transaction at a time; the next is taken while a result waits
// steps: a rejected request goes from decode to done; allocate reads and loads
//   each row scanned, then steps bits in the hit row; ranges load a row, walk it
//   frame by frame and write it back at each row boundary crossed and at the end
// reset: control state, free count and row valid bits clear under reset;
//   unwritten rows read as all taken, so no clearing pass is needed
`default_nettype none

module bitmap_page_frame_allocator_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic [bpfa_pkg::FRAME_W-1:0]  in_frame,
  input  wire logic [bpfa_pkg::COUNT_W-1:0]  in_count,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_status,
  output logic [bpfa_pkg::FRAME_W-1:0]       out_given_frame,
  output logic [bpfa_pkg::COUNT_W-1:0]       out_free_frames,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bpfa_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bpfa_pkg::DATA_W-1:0]   pwdata,
  output logic [bpfa_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int BW = bpfa_pkg::BYTES_W;
  localparam int DW = bpfa_pkg::DATA_W;

  logic [BW-1:0]   bitmap_bytes_r;
  logic            reg_hit;
  bpfa_pkg::cmd_t  cmd;
  bpfa_pkg::stat_t stat;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == bpfa_pkg::REG_BITMAP_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_bytes_r <= BW'(bpfa_pkg::STORE_BYTES);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      bitmap_bytes_r <= pwdata[BW-1:0];
    end
  end

  assign prdata = (psel && reg_hit) ? {{(DW-BW){1'b0}}, bitmap_bytes_r} : '0;

  // sequencer
  bpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store and counters
  bpfa_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_frame        (in_frame),
    .in_count        (in_count),
    .bitmap_bytes    (bitmap_bytes_r),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_given_frame (out_given_frame),
    .out_free_frames (out_free_frames)
  );

  // a taken transaction holds off the next request in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request channel open straight after a transaction");

  // a handed-out frame comes only with success
  a_given_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_given_frame != '0)) |-> !out_status)
    else $error("frame handed out on a failed request");

  // the free count never exceeds the store size
  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_free_frames <= bpfa_pkg::COUNT_W'(bpfa_pkg::MAX_FRAMES)))
    else $error("free count above store size");

  // a result appears only while a transaction is in flight
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a transaction in flight");

endmodule

`default_nettype wire

/* bench/tb_bitmap_page_frame_allocator_top.sv */
// ----------------------------------------------------------------------------
// tb_bitmap_page_frame_allocator_top
// Self-checking bench for the bitmap page frame allocator. A clocked driver
// feeds requests from a queue while a mirror of the frame bitmap predicts
// each result; a clocked monitor compares every result transaction field by
// field. Runs a directed opening, then random phases with different tracked
// sizes and different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bitmap_page_frame_allocator_top;

  localparam int RUN_LIMIT    = 4000000;
  localparam int PHASE_ITEMS  = 140;
  localparam int SETTLE_TICKS = 8;
  localparam int DRAIN_TICKS  = 64;
  localparam int FW           = bpfa_pkg::FRAME_W;
  localparam int CW           = bpfa_pkg::COUNT_W;
  localparam int MAXF         = bpfa_pkg::MAX_FRAMES;

  typedef struct packed {
    bpfa_pkg::req_t kind;
    logic [FW-1:0]  frame;
    logic [CW-1:0]  count;
  } frame_req_t;

  typedef struct packed {
    logic          status;
    logic [FW-1:0] given;
    logic [CW-1:0] free;
  } alloc_result_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // request channel
  logic          in_valid    = 1'b0;
  logic          in_stall;
  logic [1:0]    in_req_type = 2'd0;
  logic [FW-1:0] in_frame    = '0;
  logic [CW-1:0] in_count    = '0;

  // result channel
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          out_status;
  logic [FW-1:0] out_given_frame;
  logic [CW-1:0] out_free_frames;

  // register port
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [bpfa_pkg::ADDR_W-1:0] paddr   = '0;
  logic [bpfa_pkg::DATA_W-1:0] pwdata  = '0;
  logic [bpfa_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  // mirror of the allocator state
  logic [MAXF-1:0]              taken_map;
  int unsigned                  free_cnt;
  logic [bpfa_pkg::BYTES_W-1:0] tracked_bytes;

  frame_req_t    pend_q[$];
  alloc_result_t expected_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned fail_cnt      = 0;
  int unsigned cycle_cnt     = 0;

  bitmap_page_frame_allocator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_frame        (in_frame),
    .in_count        (in_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_given_frame (out_given_frame),
    .out_free_frames (out_free_frames),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // mirror bit updates, free count moves only on a real change
  function automatic void take_frame(input int unsigned f);
    if (!taken_map[f]) begin
      taken_map[f] = 1'b1;
      if (free_cnt > 0) free_cnt--;
    end
  endfunction

  function automatic void drop_frame(input int unsigned f);
    if (taken_map[f]) begin
      taken_map[f] = 1'b0;
      if (free_cnt < MAXF) free_cnt++;
    end
  endfunction

  function automatic int unsigned tracked_frames();
    return ((tracked_bytes > bpfa_pkg::STORE_BYTES) ? bpfa_pkg::STORE_BYTES
                                                     : int'(tracked_bytes)) * 8;
  endfunction

  // apply one request to the mirror and return the result it should give
  function automatic alloc_result_t apply_request(input bpfa_pkg::req_t kind,
                                                  input logic [FW-1:0] start,
                                                  input logic [CW-1:0] cnt);
    alloc_result_t res;
    int unsigned   lim;
    int unsigned   f;
    int unsigned   n;
    lim        = tracked_frames();
    res.status = 1'b0;
    res.given  = '0;
    if (kind == bpfa_pkg::REQ_ALLOC) begin
      // first fit from frame 1, frame 0 never handed out
      res.status = 1'b1;
      if (cnt == 1) begin
        for (f = 1; f < lim; f++) begin
          if (!taken_map[f]) begin
            take_frame(f);
            res.given  = FW'(f);
            res.status = 1'b0;
            break;
          end
        end
      end
    end else if (start >= lim) begin
      res.status = 1'b1;
    end else if (kind == bpfa_pkg::REQ_FREE) begin
      if (cnt != 1) res.status = 1'b1;
      else drop_frame(start);
    end else if (kind == bpfa_pkg::REQ_RESERVE) begin
      f = start;
      n = cnt;
      while (n > 0 && f < lim) begin
        if (taken_map[f]) begin
          res.status = 1'b1;
          break;
        end
        take_frame(f);
        n--;
        f++;
      end
    end else begin
      f = start;
      n = cnt;
      while (n > 0 && f < lim) begin
        drop_frame(f);
        n--;
        f++;
      end
    end
    res.free = CW'(free_cnt);
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin : drive
    frame_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(apply_request(bpfa_pkg::req_t'(in_req_type), in_frame,
                                           in_count));
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pend_q.pop_front();
          in_req_type <= nxt.kind;
          in_frame    <= nxt.frame;
          in_count    <= nxt.count;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result monitor
  always @(posedge clk) begin : monitor
    alloc_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_cnt++;
        end
        if (out_given_frame !== want.given) begin
          $error("given_frame: expected %0d, got %0d", want.given, out_given_frame);
          fail_cnt++;
        end
        if (out_free_frames !== want.free) begin
          $error("free_frames: expected %0d, got %0d", want.free, out_free_frames);
          fail_cnt++;
        end
      end
    end
  end

  task automatic push_req(input bpfa_pkg::req_t kind, input int unsigned frame,
                          input int unsigned count);
    frame_req_t r;
    r.kind  = kind;
    r.frame = FW'(frame);
    r.count = CW'(count);
    pend_q.push_back(r);
  endtask

  // block idle: nothing queued, nothing in flight, then a short pause
  task automatic wait_idle();
    while (pend_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_bytes(input int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bpfa_pkg::ADDR_W'(4 * int'(bpfa_pkg::REG_BITMAP_BYTES));
    pwdata  <= bpfa_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    tracked_bytes  = bpfa_pkg::BYTES_W'(value);
    @(negedge clk);
  endtask

  // start frame: mostly in the low window where allocation happens
  function automatic int unsigned pick_start(input int unsigned lim, input int unsigned win);
    if ($urandom_range(99) < 75) return $urandom_range(win - 1, 0);
    return $urandom_range(lim - 1, 0);
  endfunction

  function automatic frame_req_t random_request(input int unsigned lim);
    frame_req_t  r;
    int unsigned roll;
    int unsigned win;
    int unsigned back;
    roll    = $urandom_range(99);
    win     = (lim > 512) ? 512 : lim;
    r.kind  = bpfa_pkg::REQ_ALLOC;
    r.frame = FW'($urandom);
    r.count = CW'(1);
    if (roll < 32) begin
      r.kind = bpfa_pkg::REQ_ALLOC;
    end else if (roll < 52) begin
      r.kind  = bpfa_pkg::REQ_FREE;
      r.frame = FW'(pick_start(lim, win));
    end else if (roll < 70) begin
      r.kind  = bpfa_pkg::REQ_RESERVE;
      r.frame = FW'(pick_start(lim, win));
      r.count = CW'($urandom_range(16, 0));
    end else if (roll < 88) begin
      r.kind  = bpfa_pkg::REQ_RELEASE;
      r.frame = FW'(pick_start(lim, win));
      r.count = CW'($urandom_range(48, 0));
    end else if (roll < 93) begin
      // wrong count on a single-frame request
      r.kind  = $urandom_range(1) ? bpfa_pkg::REQ_ALLOC : bpfa_pkg::REQ_FREE;
      r.frame = FW'(pick_start(lim, win));
      r.count = $urandom_range(1) ? CW'(MAXF) : CW'($urandom_range(MAXF, 0));
      if (r.count == 1) r.count = '0;
    end else if (roll < 97) begin
      // start beyond the tracked frames, or high frames when all are tracked
      r.kind  = bpfa_pkg::req_t'($urandom_range(bpfa_pkg::REQ_RELEASE,
                                                bpfa_pkg::REQ_FREE));
      r.frame = (lim < MAXF) ? FW'($urandom_range(MAXF - 1, lim))
                             : FW'($urandom_range(MAXF - 1, MAXF - 64));
      r.count = CW'($urandom_range(8, 0));
    end else begin
      // long range cut short at the last tracked frame
      back    = $urandom_range((lim > 64) ? 64 : lim, 1);
      r.kind  = $urandom_range(1) ? bpfa_pkg::REQ_RESERVE : bpfa_pkg::REQ_RELEASE;
      r.frame = FW'(lim - back);
      r.count = $urandom_range(1) ? CW'(MAXF) : CW'($urandom_range(MAXF, 64));
    end
    return r;
  endfunction

  // run limit
  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    int unsigned sizes [8];
    int unsigned lim;
    int unsigned p;
    int unsigned i;
    taken_map     = '1;
    free_cnt      = 0;
    tracked_bytes = bpfa_pkg::BYTES_W'(bpfa_pkg::STORE_BYTES);
    sizes         = '{16, 2048, 40, 1, 300, 4095, 8, 0};
    sizes[7]      = $urandom_range(bpfa_pkg::STORE_BYTES, 1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: everything taken after reset, full size
    push_req(bpfa_pkg::REQ_ALLOC, 0, 1);
    push_req(bpfa_pkg::REQ_FREE, 0, 1);
    push_req(bpfa_pkg::REQ_ALLOC, 0, 1);
    push_req(bpfa_pkg::REQ_RELEASE, MAXF - 8, MAXF);
    push_req(bpfa_pkg::REQ_ALLOC, MAXF - 1, 1);
    push_req(bpfa_pkg::REQ_RELEASE, 1, 100);
    push_req(bpfa_pkg::REQ_RESERVE, 50, 60);
    push_req(bpfa_pkg::REQ_ALLOC, 0, 0);
    push_req(bpfa_pkg::REQ_ALLOC, 0, 2);
    push_req(bpfa_pkg::REQ_FREE, 5, 0);
    push_req(bpfa_pkg::REQ_FREE, 5, MAXF);
    push_req(bpfa_pkg::REQ_RESERVE, 10, 0);
    push_req(bpfa_pkg::REQ_FREE, 3, 1);
    push_req(bpfa_pkg::REQ_RESERVE, 2, 3);
    push_req(bpfa_pkg::REQ_ALLOC, 0, 1);
    push_req(bpfa_pkg::REQ_RESERVE, MAXF - 4, MAXF);
    push_req(bpfa_pkg::REQ_FREE, MAXF - 1, 1);
    push_req(bpfa_pkg::REQ_ALLOC, 0, 1);
    wait_idle();

    // directed: smallest size, then none tracked, then clamped oversize
    write_bytes(1);
    push_req(bpfa_pkg::REQ_FREE, 8, 1);
    push_req(bpfa_pkg::REQ_RESERVE, MAXF - 1, 1);
    push_req(bpfa_pkg::REQ_RELEASE, 0, MAXF);
    push_req(bpfa_pkg::REQ_ALLOC, 0, 1);
    push_req(bpfa_pkg::REQ_ALLOC, 0, 1);
    wait_idle();
    write_bytes(0);
    push_req(bpfa_pkg::REQ_ALLOC, 0, 1);
    push_req(bpfa_pkg::REQ_RELEASE, 0, 5);
    wait_idle();
    write_bytes(4095);
    push_req(bpfa_pkg::REQ_RELEASE, 16000, 5);
    wait_idle();

    // random phases, idling pattern rotates
    for (p = 0; p < 8; p++) begin
      write_bytes(sizes[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 79;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 79;
        end
        default: begin
          send_idle_pct = 38;
          stall_pct     = 38;
        end
      endcase
      lim = tracked_frames();
      for (i = 0; i < PHASE_ITEMS; i++) pend_q.push_back(random_request(lim));
      wait_idle();
    end

    // drain and final verdict
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (DRAIN_TICKS) @(negedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d result transactions never arrived", expected_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* bitmap_page_frame_allocator_top.f */
rtl/bpfa_pkg.sv
rtl/bpfa_datapath.sv
rtl/bpfa_ctrl.sv
rtl/bitmap_page_frame_allocator_top.sv
bench/tb_bitmap_page_frame_allocator_top.sv
